// File: rtl/plb_pkg.sv
// Shared types and constants for the positional list buffer.
package plb_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 6;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_DEL_FRONT = 3'd2,
        CMD_DEL_BACK  = 3'd3,
        CMD_INS_AT    = 3'd4,
        CMD_DEL_AT    = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [CMP_W-1:0] pos;
    } t_shift_ctl;

endpackage

// File: rtl/positional_list_buffer.sv
// Top level: ordered list of signed words held in a shifting chain of cells.
//
//  channel  | handshake            | fields
//  ---------+----------------------+------------------------------------------
//  command  | i_start / o_busy     | i_command, i_value, i_position
//  result   | o_valid (strobe)     | o_status, o_removed_value, o_element_count
//
// One command per cycle while o_busy is low: every cell shifts in the same
// cycle, so a command taken at one edge has its result strobed for the single
// following cycle. The removed word is picked by an OR collect across all cells.
// o_busy is high for one cycle after reset, low from then on.
// Synchronous active-low reset empties the list; cell contents are not reset.
// The receiver cannot stall; results are never held.
module positional_list_buffer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [2:0]                        i_command,
    input  logic signed [plb_pkg::DATA_W-1:0] i_value,
    input  logic [plb_pkg::POS_W-1:0]         i_position,
    output logic                              o_busy,
    output logic                              o_valid,
    output logic [1:0]                        o_status,
    output logic signed [plb_pkg::DATA_W-1:0] o_removed_value,
    output logic [5:0]                        o_element_count
);

    logic                              r_busy;
    logic                              r_valid;
    logic [1:0]                        r_status;
    logic signed [plb_pkg::DATA_W-1:0] r_removed;
    logic signed [plb_pkg::DATA_W-1:0] n_removed;
    logic                              w_accept;
    plb_pkg::t_shift_ctl               w_ctl;
    plb_pkg::t_status                  w_status;
    logic                              w_take;
    logic [plb_pkg::CNT_W-1:0]         w_count;
    logic signed [plb_pkg::DATA_W-1:0] w_data [plb_pkg::CAPACITY];
    logic signed [plb_pkg::DATA_W-1:0] w_hit  [plb_pkg::CAPACITY];
    logic signed [plb_pkg::DATA_W-1:0] w_sel;

    assign w_accept = i_start && !r_busy;

    plb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_command  (i_command),
        .i_position (i_position),
        .o_ctl      (w_ctl),
        .o_status   (w_status),
        .o_take     (w_take),
        .o_count    (w_count)
    );

    for (genvar g = 0; g < plb_pkg::CAPACITY; g++) begin : g_cell
        logic signed [plb_pkg::DATA_W-1:0] w_left;
        logic signed [plb_pkg::DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid
            assign w_left = w_data[g-1];
        end
        if (g == plb_pkg::CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_inner
            assign w_right = w_data[g+1];
        end
        plb_cell u_cell (
            .i_clk   (i_clk),
            .i_index (plb_pkg::IDX_W'(g)),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_value (i_value),
            .o_data  (w_data[g]),
            .o_hit   (w_hit[g])
        );
    end

    always_comb begin
        w_sel = '0;
        for (int k = 0; k < plb_pkg::CAPACITY; k++) begin
            w_sel = w_sel | w_hit[k];
        end
        n_removed = w_take ? w_sel : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= 1'b0;
            r_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= w_status;
            r_removed <= n_removed;
        end
    end

    assign o_busy          = r_busy;
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_element_count = 6'(w_count);

endmodule

// File: rtl/plb_cell.sv
// One storage cell of the shifting element chain.
module plb_cell (
    input  logic                           i_clk,
    input  logic [plb_pkg::IDX_W-1:0]      i_index,
    input  plb_pkg::t_shift_ctl            i_ctl,
    input  logic signed [plb_pkg::DATA_W-1:0] i_left,
    input  logic signed [plb_pkg::DATA_W-1:0] i_right,
    input  logic signed [plb_pkg::DATA_W-1:0] i_value,
    output logic signed [plb_pkg::DATA_W-1:0] o_data,
    output logic signed [plb_pkg::DATA_W-1:0] o_hit
);

    logic signed [plb_pkg::DATA_W-1:0] r_data;
    logic signed [plb_pkg::DATA_W-1:0] n_data;
    logic [plb_pkg::CMP_W-1:0]         w_idx;

    assign w_idx = plb_pkg::CMP_W'(i_index);

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.op)
            plb_pkg::OP_INS: begin
                if (w_idx > i_ctl.pos) begin
                    n_data = i_left;
                end else if (w_idx == i_ctl.pos) begin
                    n_data = i_value;
                end
            end
            plb_pkg::OP_DEL: begin
                if (w_idx >= i_ctl.pos) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // word under the selected position, zero elsewhere, for the OR collect
    assign o_hit  = (w_idx == i_ctl.pos) ? r_data : '0;

endmodule

// File: rtl/plb_ctrl.sv
// Command decode, status checks and element count for the list buffer.
module plb_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [2:0]                   i_command,
    input  logic [plb_pkg::POS_W-1:0]    i_position,
    output plb_pkg::t_shift_ctl          o_ctl,
    output plb_pkg::t_status             o_status,
    output logic                         o_take,
    output logic [plb_pkg::CNT_W-1:0]    o_count
);

    logic [plb_pkg::CNT_W-1:0] r_count;
    logic [plb_pkg::CNT_W-1:0] n_count;
    logic [plb_pkg::CMP_W-1:0] w_cnt;
    logic [plb_pkg::CMP_W-1:0] w_cap;
    logic [plb_pkg::CMP_W-1:0] w_pos;
    logic                      w_ins;
    logic                      w_del;
    plb_pkg::t_status          w_status;

    assign w_cnt = plb_pkg::CMP_W'(r_count);
    assign w_cap = plb_pkg::CMP_W'(plb_pkg::CAPACITY);

    always_comb begin
        w_ins = 1'b0;
        w_del = 1'b0;
        w_pos = '0;
        unique case (plb_pkg::t_cmd'(i_command))
            plb_pkg::CMD_INS_FRONT: w_ins = 1'b1;
            plb_pkg::CMD_INS_BACK: begin
                w_ins = 1'b1;
                w_pos = w_cnt;
            end
            plb_pkg::CMD_DEL_FRONT: w_del = 1'b1;
            plb_pkg::CMD_DEL_BACK: begin
                w_del = 1'b1;
                w_pos = (w_cnt == '0) ? '0 : w_cnt - 1'b1;
            end
            plb_pkg::CMD_INS_AT: begin
                w_ins = 1'b1;
                w_pos = plb_pkg::CMP_W'(i_position);
            end
            plb_pkg::CMD_DEL_AT: begin
                w_del = 1'b1;
                w_pos = plb_pkg::CMP_W'(i_position);
            end
            default: ;
        endcase

        // position check ranks ahead of the full check on inserts
        if (w_ins) begin
            if (w_pos > w_cnt) begin
                w_status = plb_pkg::ST_BADPOS;
            end else if (w_cnt >= w_cap) begin
                w_status = plb_pkg::ST_FULL;
            end else begin
                w_status = plb_pkg::ST_DONE;
            end
        end else if (w_del) begin
            if (w_cnt == '0) begin
                w_status = plb_pkg::ST_EMPTY;
            end else if (w_pos >= w_cnt) begin
                w_status = plb_pkg::ST_BADPOS;
            end else begin
                w_status = plb_pkg::ST_DONE;
            end
        end else begin
            w_status = plb_pkg::ST_BADPOS;
        end

        o_ctl.pos = w_pos;
        o_ctl.op  = plb_pkg::OP_HOLD;
        n_count   = r_count;
        if (i_accept && w_status == plb_pkg::ST_DONE) begin
            if (w_ins) begin
                o_ctl.op = plb_pkg::OP_INS;
                n_count  = r_count + 1'b1;
            end else begin
                o_ctl.op = plb_pkg::OP_DEL;
                n_count  = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_status = w_status;
    assign o_take   = w_del && (w_status == plb_pkg::ST_DONE);
    assign o_count  = r_count;

endmodule

// File: rtl/plb_checker.sv
// Port-level checks on the list buffer, bound to the top level.
module plb_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              o_busy,
    input  logic                              o_valid,
    input  logic [1:0]                        o_status,
    input  logic signed [plb_pkg::DATA_W-1:0] o_removed_value,
    input  logic [5:0]                        o_element_count
);

    logic w_accept;

    assign w_accept = i_start && !o_busy;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("command taken but no result strobe");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !o_valid)
        else $error("result strobe without a command");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != plb_pkg::ST_DONE) |-> o_removed_value == '0)
        else $error("failed command reports a removed word");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == plb_pkg::ST_FULL)
            |-> o_element_count == 6'(plb_pkg::CAPACITY))
        else $error("full status with count below capacity");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == plb_pkg::ST_EMPTY) |-> o_element_count == '0)
        else $error("empty status with a nonzero count");

endmodule

bind positional_list_buffer plb_checker u_plb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .o_valid         (o_valid),
    .o_status        (o_status),
    .o_removed_value (o_removed_value),
    .o_element_count (o_element_count)
);
